/* sv/mcavg_pkg.sv */
// ----------------------------------------------------------------------------
// mcavg_pkg
// Shared constants, types and helpers for the multichannel averager.
// ----------------------------------------------------------------------------
package mcavg_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 8;
    localparam int DEFAULT_SAMPLE_BITS  = 10;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int CHAN_CFG_W = 4;
    localparam int PASS_W     = 8;
    localparam int SUM_W      = 18;
    localparam int STEP_W     = 5;
    localparam int CHAN_OUT_W = 3;
    localparam int AVG_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES   = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic acc;
        logic div_load;
        logic div_step;
        logic idx_next;
        logic frame_done;
    } t_cmd;

    typedef struct packed {
        logic sweep_end;
        logic frame_due;
        logic div_done;
        logic last_ch;
    } t_sts;

    function automatic logic [PASS_W-1:0] eff_passes(input logic [PASS_W-1:0] p);
        eff_passes = (p == '0) ? PASS_W'(1) : p;
    endfunction

endpackage

/* sv/mcavg_smp_if.sv */
// ----------------------------------------------------------------------------
// mcavg_smp_if
// Sample channel: one converter sample per item.
// ----------------------------------------------------------------------------
interface mcavg_smp_if #(
    parameter int SAMPLE_BITS = mcavg_pkg::DEFAULT_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* sv/mcavg_res_if.sv */
// ----------------------------------------------------------------------------
// mcavg_res_if
// Result channel: one channel average per item.
// ----------------------------------------------------------------------------
interface mcavg_res_if;
    logic                              valid;
    logic                              ready;
    logic [mcavg_pkg::CHAN_OUT_W-1:0]  channel;
    logic [mcavg_pkg::AVG_W-1:0]       average;
    logic                              last_of_frame;

    modport source (output valid, output channel, output average, output last_of_frame,
                    input ready);
    modport sink   (input valid, input channel, input average, input last_of_frame,
                    output ready);
endinterface

/* sv/mcavg_ctrl.sv */
// ----------------------------------------------------------------------------
// mcavg_ctrl
// Sequencer: accept samples, then run divide and readout for each channel.
// ----------------------------------------------------------------------------
module mcavg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mcavg_pkg::t_sts   i_sts,
    output mcavg_pkg::t_cmd   o_cmd
);

    mcavg_pkg::t_state r_state;
    mcavg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcavg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcavg_pkg::ST_IDLE: begin
                if (i_in_valid && i_sts.frame_due) begin
                    n_state = mcavg_pkg::ST_LOAD;
                end
            end
            mcavg_pkg::ST_LOAD: begin
                n_state = mcavg_pkg::ST_DIV;
            end
            mcavg_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = mcavg_pkg::ST_OUT;
                end
            end
            mcavg_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.last_ch ? mcavg_pkg::ST_IDLE : mcavg_pkg::ST_LOAD;
                end
            end
            default: n_state = mcavg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            mcavg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.acc  = i_in_valid;
            end
            mcavg_pkg::ST_LOAD: begin
                o_cmd.div_load = 1'b1;
            end
            mcavg_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            mcavg_pkg::ST_OUT: begin
                o_out_valid      = 1'b1;
                o_cmd.frame_done = i_out_ready && i_sts.last_ch;
                o_cmd.idx_next   = i_out_ready && !i_sts.last_ch;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/mcavg_dp.sv */
// ----------------------------------------------------------------------------
// mcavg_dp
// Datapath: config registers, accumulators, pass counter, serial divider.
// ----------------------------------------------------------------------------
module mcavg_dp #(
    parameter int MAX_CHANNELS = mcavg_pkg::DEFAULT_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mcavg_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mcavg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mcavg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  mcavg_pkg::t_cmd                      i_cmd,
    output mcavg_pkg::t_sts                      o_sts,
    output logic [mcavg_pkg::CHAN_OUT_W-1:0]     o_channel,
    output logic [mcavg_pkg::AVG_W-1:0]          o_average
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int N_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W  = mcavg_pkg::SUM_W;
    localparam int PASS_W = mcavg_pkg::PASS_W;

    logic [mcavg_pkg::CHAN_CFG_W-1:0] r_chans;
    logic [PASS_W-1:0]                r_passes;
    logic [PASS_W-1:0]                r_left;
    logic [CH_W-1:0]                  r_cur;
    logic [CH_W-1:0]                  r_out_idx;
    logic [SUM_W-1:0]                 r_sums [MAX_CHANNELS];
    logic [PASS_W-1:0]                r_rem;
    logic [SUM_W-1:0]                 r_quo;
    logic [mcavg_pkg::STEP_W-1:0]     r_step;

    logic [N_W-1:0]    eff_n;
    logic [PASS_W-1:0] eff_p;
    logic [CH_W-1:0]   rd_addr;
    logic [SUM_W-1:0]  rd_sum;
    logic [SUM_W-1:0]  sum_new;
    logic [N_W-1:0]    cur_inc;
    logic [N_W-1:0]    out_inc;
    logic [PASS_W:0]   rem_sh;
    logic [PASS_W+1:0] diff;
    logic [15:0]       chan_ext;

    always_comb begin
        if (r_chans == '0) begin
            eff_n = N_W'(1);
        end else if ({1'b0, r_chans} > 5'(MAX_CHANNELS)) begin
            eff_n = N_W'(MAX_CHANNELS);
        end else begin
            eff_n = N_W'(r_chans);
        end
    end

    assign eff_p   = mcavg_pkg::eff_passes(r_passes);
    assign rd_addr = i_cmd.acc ? r_cur : r_out_idx;
    assign rd_sum  = r_sums[rd_addr];
    assign sum_new = rd_sum + SUM_W'(i_sample);
    assign cur_inc = N_W'(r_cur) + N_W'(1);
    assign out_inc = N_W'(r_out_idx) + N_W'(1);
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign diff    = {1'b0, rem_sh} - {2'b00, eff_p};

    assign o_sts.sweep_end = (cur_inc >= eff_n);
    assign o_sts.frame_due = o_sts.sweep_end && (r_left <= PASS_W'(1));
    assign o_sts.div_done  = (r_step == mcavg_pkg::STEP_W'(SUM_W - 1));
    assign o_sts.last_ch   = (out_inc == eff_n);

    assign chan_ext  = 16'(r_out_idx);
    assign o_channel = chan_ext[mcavg_pkg::CHAN_OUT_W-1:0];
    assign o_average = r_quo[mcavg_pkg::AVG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans  <= mcavg_pkg::CHAN_CFG_W'(1);
            r_passes <= PASS_W'(1);
            r_left   <= PASS_W'(1);
            r_cur    <= '0;
            r_out_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mcavg_pkg::CFG_CHANNELS: begin
                        r_chans <= i_cfg_data[mcavg_pkg::CHAN_CFG_W-1:0];
                    end
                    mcavg_pkg::CFG_PASSES: begin
                        r_passes <= i_cfg_data[PASS_W-1:0];
                        r_left   <= mcavg_pkg::eff_passes(i_cfg_data[PASS_W-1:0]);
                    end
                    default: begin
                        r_chans <= r_chans;
                    end
                endcase
            end
            if (i_cmd.acc) begin
                if (o_sts.sweep_end) begin
                    r_cur <= '0;
                    if (!o_sts.frame_due) begin
                        r_left <= r_left - PASS_W'(1);
                    end
                end else begin
                    r_cur <= r_cur + CH_W'(1);
                end
            end
            if (i_cmd.idx_next) begin
                r_out_idx <= r_out_idx + CH_W'(1);
            end
            if (i_cmd.frame_done) begin
                r_out_idx <= '0;
                r_left    <= eff_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_sums[i] <= '0;
            end
        end else if (i_cmd.frame_done) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_sums[i] <= '0;
            end
        end else if (i_cmd.acc) begin
            r_sums[r_cur] <= sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= '0;
            r_quo  <= rd_sum;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + mcavg_pkg::STEP_W'(1);
            if (!diff[PASS_W+1]) begin
                r_rem <= diff[PASS_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[PASS_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

/* sv/multichannel_adc_averager_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_adc_averager_unit
// Round-robin converter averager with per-channel accumulators.
//
// Samples enter on i_smp, one item per channel in round-robin order starting
// at channel 0. Each accepted sample is summed into its channel's accumulator
// in the accepting cycle, so i_smp.ready stays high between frames and a
// sample can be taken every cycle.
// After passes_per_result full sweeps the unit stops taking samples and emits
// one item per channel in use on o_res, channel 0 first, the final one with
// last_of_frame set. Each average comes from a restoring divider that
// retires one quotient bit per cycle: a load state, then a divide state that
// forms all 18 quotient bits, then the item is held on o_res until taken.
// If the receiver stalls, the result holds and the unit waits; no sample is
// taken until the whole frame has been delivered. Then the accumulators clear
// and the pass counter reloads.
// Reset (synchronous, active low) clears all accumulators, selects channel
// 0, and sets both registers and the pass counter to one. Registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data: index 0 channels in use,
// index 1 passes per result (writing it also reloads the pass counter).
// ----------------------------------------------------------------------------
module multichannel_adc_averager_unit #(
    parameter int MAX_CHANNELS = mcavg_pkg::DEFAULT_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mcavg_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcavg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mcavg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mcavg_smp_if.sink                         i_smp,
    mcavg_res_if.source                       o_res
);

    mcavg_pkg::t_cmd cmd;
    mcavg_pkg::t_sts sts;

    mcavg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (i_smp.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mcavg_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_smp.sample),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_channel  (o_res.channel),
        .o_average  (o_res.average)
    );

    assign o_res.last_of_frame = sts.last_ch;

endmodule
